// ===== rtl/mks_pkg.sv =====
package mks_pkg;

   // field widths
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned DIT_W   = 16;
   localparam int unsigned RATIO_W = 8;
   localparam int unsigned DUR_W   = 21;
   localparam int unsigned PROD_W  = DIT_W + RATIO_W;
   localparam int unsigned CSR_W   = 16;

   // configuration register indexes and reset values
   localparam logic CSR_DIT_LENGTH = 1'b0;
   localparam logic CSR_DAH_RATIO  = 1'b1;
   localparam logic [DIT_W-1:0]   DIT_RESET   = 16'd6000;
   localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd30;

   // serial multiply / divide step counts
   localparam int unsigned MUL_STEPS = RATIO_W;
   localparam int unsigned DIV_STEPS = PROD_W;
   localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
   localparam logic [4:0]  DIV_BASE  = 5'd10;

   // longest Morse code in the table
   localparam int unsigned MAX_ELEM = 6;

   typedef enum logic [1:0] {
      DAH_IDLE,
      DAH_MUL,
      DAH_DIV
   } dah_state_type;

   typedef enum logic [1:0] {
      EMT_IDLE,
      EMT_WAIT,
      EMT_SEND
   } emit_state_type;

   typedef struct packed {
      logic               start;
      logic [DIT_W-1:0]   dit;
      logic [RATIO_W-1:0] ratio;
   } dah_cmd_type;

   typedef struct packed {
      logic             done;
      logic [DUR_W-1:0] dah;
   } dah_res_type;

   // one character: space flag, element count, dah mask (bit i = element i)
   typedef struct packed {
      logic                space;
      logic [2:0]          len;
      logic [MAX_ELEM-1:0] dahs;
   } code_type;

   function automatic code_type mks_lookup(input logic [CHAR_W-1:0] raw);
      logic [CHAR_W-1:0] c;
      code_type          r;
      c = raw;
      // fold lower case; NUL keys as a space
      if (c >= 8'h61 && c <= 8'h7a)
         c = c - 8'd32;
      if (c == 8'h00)
         c = 8'h20;
      r.space = 1'b0;
      unique case (c)
         8'h30: begin r.len = 3'd5; r.dahs = 6'b011111; end
         8'h31: begin r.len = 3'd5; r.dahs = 6'b011110; end
         8'h32: begin r.len = 3'd5; r.dahs = 6'b011100; end
         8'h33: begin r.len = 3'd5; r.dahs = 6'b011000; end
         8'h34: begin r.len = 3'd5; r.dahs = 6'b010000; end
         8'h35: begin r.len = 3'd5; r.dahs = 6'b000000; end
         8'h36: begin r.len = 3'd5; r.dahs = 6'b000001; end
         8'h37: begin r.len = 3'd5; r.dahs = 6'b000011; end
         8'h38: begin r.len = 3'd5; r.dahs = 6'b000111; end
         8'h39: begin r.len = 3'd5; r.dahs = 6'b001111; end
         8'h41: begin r.len = 3'd2; r.dahs = 6'b000010; end
         8'h42: begin r.len = 3'd4; r.dahs = 6'b000001; end
         8'h43: begin r.len = 3'd4; r.dahs = 6'b000101; end
         8'h44: begin r.len = 3'd3; r.dahs = 6'b000001; end
         8'h45: begin r.len = 3'd1; r.dahs = 6'b000000; end
         8'h46: begin r.len = 3'd4; r.dahs = 6'b000100; end
         8'h47: begin r.len = 3'd3; r.dahs = 6'b000011; end
         8'h48: begin r.len = 3'd4; r.dahs = 6'b000000; end
         8'h49: begin r.len = 3'd2; r.dahs = 6'b000000; end
         8'h4a: begin r.len = 3'd4; r.dahs = 6'b001110; end
         8'h4b: begin r.len = 3'd3; r.dahs = 6'b000101; end
         8'h4c: begin r.len = 3'd4; r.dahs = 6'b000010; end
         8'h4d: begin r.len = 3'd2; r.dahs = 6'b000011; end
         8'h4e: begin r.len = 3'd2; r.dahs = 6'b000001; end
         8'h4f: begin r.len = 3'd3; r.dahs = 6'b000111; end
         8'h50: begin r.len = 3'd4; r.dahs = 6'b000110; end
         8'h51: begin r.len = 3'd4; r.dahs = 6'b001011; end
         8'h52: begin r.len = 3'd3; r.dahs = 6'b000010; end
         8'h53: begin r.len = 3'd3; r.dahs = 6'b000000; end
         8'h54: begin r.len = 3'd1; r.dahs = 6'b000001; end
         8'h55: begin r.len = 3'd3; r.dahs = 6'b000100; end
         8'h56: begin r.len = 3'd4; r.dahs = 6'b001000; end
         8'h57: begin r.len = 3'd3; r.dahs = 6'b000110; end
         8'h58: begin r.len = 3'd4; r.dahs = 6'b001001; end
         8'h59: begin r.len = 3'd4; r.dahs = 6'b001101; end
         8'h5a: begin r.len = 3'd4; r.dahs = 6'b000011; end
         8'h2f: begin r.len = 3'd5; r.dahs = 6'b001001; end
         8'h2e: begin r.len = 3'd6; r.dahs = 6'b101010; end
         8'h2d: begin r.len = 3'd6; r.dahs = 6'b100001; end
         8'h2c: begin r.len = 3'd6; r.dahs = 6'b110011; end
         8'h3a: begin r.len = 3'd6; r.dahs = 6'b000111; end
         8'h27: begin r.len = 3'd6; r.dahs = 6'b011110; end
         8'h28: begin r.len = 3'd6; r.dahs = 6'b101101; end
         8'h29: begin r.len = 3'd6; r.dahs = 6'b101101; end
         8'h3d: begin r.len = 3'd5; r.dahs = 6'b010001; end
         8'h2b: begin r.len = 3'd5; r.dahs = 6'b001010; end
         8'h22: begin r.len = 3'd6; r.dahs = 6'b010010; end
         8'h20: begin r.len = 3'd1; r.dahs = 6'b000000; r.space = 1'b1; end
         // question mark, and anything not in the table
         default: begin r.len = 3'd6; r.dahs = 6'b001100; end
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/mks_req_if.sv =====
interface mks_req_if;
   import mks_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

// ===== rtl/mks_rsp_if.sv =====
interface mks_rsp_if;
   import mks_pkg::*;

   logic             valid;
   logic             ready;
   logic             tone_on;
   logic [DUR_W-1:0] duration;
   logic             last_segment;

   modport source (output valid, output tone_on, output duration, output last_segment,
                   input ready);
   modport sink   (input valid, input tone_on, input duration, input last_segment,
                   output ready);
endinterface

// ===== rtl/mks_dah_unit.sv =====
// dah = floor(dit * ratio / 10): shift-add multiply one ratio bit per cycle,
// then restoring divide by ten one quotient bit per cycle
module mks_dah_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  mks_pkg::dah_cmd_type cmd,
   output mks_pkg::dah_res_type res
);
   import mks_pkg::*;

   dah_state_type      state_ff, state_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [PROD_W-1:0]  mcand_ff, mcand_in;
   logic [RATIO_W-1:0] mplier_ff, mplier_in;
   logic [3:0]         rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               done_ff, done_in;
   logic [4:0]         rem_try;
   logic               qbit;

   // one divide step
   assign rem_try = {rem_ff, acc_ff[PROD_W-1]};
   assign qbit    = (rem_try >= DIV_BASE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DAH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      step_ff   <= step_in;
   end

   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         DAH_IDLE: begin
            if (cmd.start) begin
               acc_in    = '0;
               mcand_in  = {{(PROD_W-DIT_W){1'b0}}, cmd.dit};
               mplier_in = cmd.ratio;
               step_in   = '0;
               state_in  = DAH_MUL;
            end
         end
         DAH_MUL: begin
            if (mplier_ff[0])
               acc_in = acc_ff + mcand_ff;
            mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[RATIO_W-1:1]};
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
               step_in  = '0;
               rem_in   = '0;
               state_in = DAH_DIV;
            end
         end
         DAH_DIV: begin
            // dividend shifts out the top, quotient shifts in the bottom
            rem_in  = qbit ? 4'(rem_try - DIV_BASE) : rem_try[3:0];
            acc_in  = {acc_ff[PROD_W-2:0], qbit};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = DAH_IDLE;
            end
         end
         default: state_in = DAH_IDLE;
      endcase
   end

   assign res.done = done_ff;
   assign res.dah  = acc_ff[DUR_W-1:0];

endmodule

// ===== rtl/mks_emitter.sv =====
// Holds the looked-up code and sends two segments per element
module mks_emitter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic [mks_pkg::CHAR_W-1:0] char_code,
   input  logic [mks_pkg::DIT_W-1:0]  dit,
   input  mks_pkg::dah_res_type      dah_res,
   output logic                      busy,
   mks_rsp_if.source                 rsp
);
   import mks_pkg::*;

   emit_state_type   state_ff, state_in;
   code_type         code_ff, code_in;
   logic [3:0]       seg_ff, seg_in;
   logic [DUR_W-1:0] dah_ff, dah_in;
   logic [DUR_W-1:0] space_ff, space_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_tone_ff, out_tone_in;
   logic [DUR_W-1:0] out_dur_ff, out_dur_in;
   logic             out_last_ff, out_last_in;
   logic [2:0]       elem;
   logic             final_elem;
   logic             slot_free;
   logic [DUR_W-1:0] dit_ext;

   assign dit_ext    = {{(DUR_W-DIT_W){1'b0}}, dit};
   assign elem       = seg_ff[3:1];
   assign final_elem = (elem == code_ff.len - 3'd1);
   assign slot_free  = !out_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EMT_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      code_ff     <= code_in;
      seg_ff      <= seg_in;
      dah_ff      <= dah_in;
      space_ff    <= space_in;
      out_tone_ff <= out_tone_in;
      out_dur_ff  <= out_dur_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      seg_in       = seg_ff;
      dah_in       = dah_ff;
      space_in     = space_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_tone_in  = out_tone_ff;
      out_dur_in   = out_dur_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         EMT_IDLE: begin
            if (take) begin
               code_in  = mks_lookup(char_code);
               seg_in   = '0;
               state_in = EMT_WAIT;
            end
         end
         EMT_WAIT: begin
            if (dah_res.done) begin
               dah_in   = dah_res.dah;
               space_in = dah_res.dah + dit_ext;
               state_in = EMT_SEND;
            end
         end
         EMT_SEND: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               if (!seg_ff[0]) begin
                  // keyed element, or the long silence of a word space
                  out_last_in = 1'b0;
                  if (code_ff.space) begin
                     out_tone_in = 1'b0;
                     out_dur_in  = space_ff;
                  end else begin
                     out_tone_in = 1'b1;
                     out_dur_in  = code_ff.dahs[elem] ? dah_ff : dit_ext;
                  end
               end else begin
                  // gap after the element
                  out_tone_in = 1'b0;
                  out_dur_in  = final_elem ? dah_ff : dit_ext;
                  out_last_in = final_elem;
                  if (final_elem)
                     state_in = EMT_IDLE;
               end
               seg_in = seg_ff + 4'd1;
            end
         end
         default: state_in = EMT_IDLE;
      endcase
   end

   assign busy             = (state_ff != EMT_IDLE);
   assign rsp.valid        = out_valid_ff;
   assign rsp.tone_on      = out_tone_ff;
   assign rsp.duration     = out_dur_ff;
   assign rsp.last_segment = out_last_ff;

endmodule

// ===== rtl/morse_keying_segmenter.sv =====
// Channel   Dir  Word                                  Handshake
// req       in   char_code[7:0]                        valid/ready
// rsp       out  tone_on, duration[20:0], last_segment valid/ready
// csr       in   csr_index, csr_write_data[15:0]       csr_write_enable
//
// A character first forms the dah length in the serial multiply/divide unit
// (multiply, then divide), then the emitter loads it and sends its segments
// (2 to 12 segments) back to back while rsp does not stall; the next word
// is taken on the cycle after the last segment is loaded.
// Reset restores dit_length 6000 and ratio 30 and empties the output word.
// A stalled rsp holds the emitter; req is taken only with the emitter idle,
// which may be while the final segment still waits in the output register.
module morse_keying_segmenter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic                       csr_index,
   input  logic [mks_pkg::CSR_W-1:0]  csr_write_data,
   mks_req_if.sink                    req,
   mks_rsp_if.source                  rsp
);
   import mks_pkg::*;

   logic [DIT_W-1:0]   dit_length_ff, dit_length_in;
   logic [RATIO_W-1:0] dah_ratio_ff, dah_ratio_in;
   logic               busy;
   logic               take;
   dah_cmd_type        dah_cmd;
   dah_res_type        dah_res;

   // configuration registers
   always_comb begin
      dit_length_in = dit_length_ff;
      dah_ratio_in  = dah_ratio_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DIT_LENGTH: dit_length_in = csr_write_data[DIT_W-1:0];
            CSR_DAH_RATIO:  dah_ratio_in  = csr_write_data[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dit_length_ff <= DIT_RESET;
         dah_ratio_ff  <= RATIO_RESET;
      end else begin
         dit_length_ff <= dit_length_in;
         dah_ratio_ff  <= dah_ratio_in;
      end
   end

   assign req.ready     = !busy;
   assign take          = req.valid && !busy;
   assign dah_cmd.start = take;
   assign dah_cmd.dit   = dit_length_ff;
   assign dah_cmd.ratio = dah_ratio_ff;

   mks_dah_unit u_dah (
      .clock (clock),
      .reset (reset),
      .cmd   (dah_cmd),
      .res   (dah_res)
   );

   mks_emitter u_emit (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .char_code (req.char_code),
      .dit       (dit_length_ff),
      .dah_res   (dah_res),
      .busy      (busy),
      .rsp       (rsp)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import mks_pkg::*;

   localparam int unsigned HALF_PERIOD   = 4;
   localparam int unsigned SETTLE_CYCLES = 80;
   localparam int unsigned REPORT_LIMIT  = 10;

   // one keyed segment as it leaves the block
   typedef struct packed {
      logic             tone_on;
      logic [DUR_W-1:0] duration;
      logic             last_segment;
   } keying_segment_type;

   // Expected keying for every accepted character, checked in order
   class keying_scoreboard;
      logic [DIT_W-1:0]   dit_len;
      logic [RATIO_W-1:0] ratio;
      string              key_chars;
      string              key_codes[49];
      keying_segment_type segment_q[$];
      int unsigned        errors;
      int unsigned        chars_noted;
      int unsigned        segments_checked;

      function new();
         dit_len   = DIT_RESET;
         ratio     = RATIO_RESET;
         key_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ/?.-,:'()=+\" ";
         key_codes = '{"-----", ".----", "..---", "...--", "....-",
                       ".....", "-....", "--...", "---..", "----.",
                       ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....",
                       "..", ".---", "-.-", ".-..", "--", "-.", "---", ".--.",
                       "--.-", ".-.", "...", "-", "..-", "...-", ".--", "-..-",
                       "-.--", "--..",
                       "-..-.", "..--..", ".-.-.-", "-....-", "--..--", "---...",
                       ".----.", "-.--.-", "-.--.-", "-...-", ".-.-.", ".-..-.",
                       " "};
      endfunction

      function void write_reg(logic idx, logic [CSR_W-1:0] data);
         if (idx == CSR_DIT_LENGTH)
            dit_len = data[DIT_W-1:0];
         else
            ratio = data[RATIO_W-1:0];
      endfunction

      // fold case, NUL as space, unknown codes as question mark
      function string code_of(logic [CHAR_W-1:0] raw);
         logic [CHAR_W-1:0] c;
         c = raw;
         if (c >= 8'h61 && c <= 8'h7a)
            c = c - 8'd32;
         if (c == 8'h00)
            c = 8'h20;
         for (int i = 0; i < key_chars.len(); i++)
            if (key_chars[i] == c)
               return key_codes[i];
         return "..--..";
      endfunction

      function void note_char(logic [CHAR_W-1:0] c);
         string              code;
         logic [31:0]        dit;
         logic [31:0]        dah;
         keying_segment_type seg;
         code = code_of(c);
         dit  = 32'(dit_len);
         dah  = (dit * 32'(ratio)) / 32'd10;
         chars_noted++;
         for (int i = 0; i < code.len(); i++) begin
            seg.tone_on      = (code[i] != " ");
            seg.last_segment = 1'b0;
            if (code[i] == "-")
               seg.duration = dah[DUR_W-1:0];
            else if (code[i] == ".")
               seg.duration = dit[DUR_W-1:0];
            else
               seg.duration = DUR_W'(dah + dit);
            segment_q.push_back(seg);
            // inter-element gap, or the closing dah silence
            seg.tone_on = 1'b0;
            if (i == code.len() - 1) begin
               seg.duration     = dah[DUR_W-1:0];
               seg.last_segment = 1'b1;
            end else begin
               seg.duration = dit[DUR_W-1:0];
            end
            segment_q.push_back(seg);
         end
      endfunction

      function void fail(string msg);
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("%0t ns: %s", $time, msg);
      endfunction

      function void check_segment(keying_segment_type got);
         keying_segment_type want;
         segments_checked++;
         if (segment_q.size() == 0) begin
            fail($sformatf("unexpected segment tone=%0b dur=%0d last=%0b",
                           got.tone_on, got.duration, got.last_segment));
            return;
         end
         want = segment_q.pop_front();
         if (got.tone_on !== want.tone_on)
            fail($sformatf("tone_on: expected %0b, got %0b", want.tone_on, got.tone_on));
         if (got.duration !== want.duration)
            fail($sformatf("duration: expected %0d, got %0d", want.duration, got.duration));
         if (got.last_segment !== want.last_segment)
            fail($sformatf("last_segment: expected %0b, got %0b",
                           want.last_segment, got.last_segment));
      endfunction

      function int unsigned pending();
         return segment_q.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic              csr_index;
   logic [CSR_W-1:0]  csr_write_data;
   bit                calm;

   mks_req_if req_ch ();
   mks_rsp_if rsp_ch ();

   keying_scoreboard board = new();

   morse_keying_segmenter i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req_ch.sink),
      .rsp              (rsp_ch.source)
   );

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [CHAR_W-1:0] pick_char();
      if ($urandom_range(0, 3) == 0)
         return CHAR_W'($urandom_range(0, 255));
      if ($urandom_range(0, 4) == 0)
         return board.key_chars[$urandom_range(0, board.key_chars.len() - 1)] | 8'h20;
      return board.key_chars[$urandom_range(0, board.key_chars.len() - 1)];
   endfunction

   // valid stays high after acceptance so back-to-back words need no toggle
   task automatic send_char(input logic [CHAR_W-1:0] c);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= c;
      do @(posedge clock); while (!req_ch.ready);
      board.note_char(c);
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i]);
   endtask

   // drop valid, wait for all segments, then let the block go quiet
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_timing(input logic [CSR_W-1:0] dit, input logic [CSR_W-1:0] ratio);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DIT_LENGTH;
      csr_write_data   <= dit;
      @(posedge clock);
      board.write_reg(CSR_DIT_LENGTH, dit);
      csr_index      <= CSR_DAH_RATIO;
      csr_write_data <= ratio;
      @(posedge clock);
      board.write_reg(CSR_DAH_RATIO, ratio);
      csr_write_enable <= 1'b0;
   endtask

   // result side backpressure
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         int unsigned stall;
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // result monitor
   always @(posedge clock) begin
      keying_segment_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.tone_on      = rsp_ch.tone_on;
         got.duration     = rsp_ch.duration;
         got.last_segment = rsp_ch.last_segment;
         board.check_segment(got);
      end
   end

   initial begin
      logic [CSR_W-1:0] dit;
      logic [CSR_W-1:0] ratio;
      req_ch.valid     <= 1'b0;
      req_ch.char_code <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_DIT_LENGTH;
      csr_write_data   <= '0;
      reset            <= 1'b1;
      calm = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset timing: case folding, punctuation, NUL, unknown and high codes
      send_string("AeZz?()\"'5,.");
      send_char(8'h00);
      send_char(8'hff);
      send_char(8'h80);
      send_char(8'h7f);
      settle();
      // zero dit and zero ratio give all-zero durations
      program_timing(16'd0, 16'd0);
      send_string("K ");
      settle();
      // widest durations; upper ratio byte must be ignored
      program_timing(16'hffff, 16'hffff);
      send_string("0 ");
      send_char(8'h00);
      settle();
      program_timing(16'd1, 16'd10);
      send_string(".-");
      settle();
      // ratio below one: dah shorter than dit
      program_timing(16'd7, 16'd5);
      send_string("T");
      settle();

      // random characters under several timings, one phase without idling
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin dit = 16'hffff; ratio = 16'd10; end
            1: begin dit = 16'd1;    ratio = 16'd255; end
            4: begin dit = 16'd6000; ratio = 16'd30; end
            default: begin
               dit   = CSR_W'($urandom_range(1, 65535));
               ratio = {8'($urandom), 8'($urandom_range(10, 255))};
            end
         endcase
         calm = (phase == 2);
         program_timing(dit, ratio);
         repeat (44) send_char(pick_char());
         settle();
      end

      board.errors += board.pending();
      $display("Keyed %0d characters into %0d checked segments across 10 timing settings,",
               board.chars_noted, board.segments_checked);
      $display("%0d mismatches in total", board.errors);
      if (board.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin
      #8000000;
      $display("Timeout with %0d segments outstanding", board.pending());
      $display("Test completed with failures");
      $finish;
   end

endmodule
